// File: rtl/ts_pkg.sv
// Package: shared types, codes and sine table builder for the timed sampler.
`timescale 1ns / 1ps

package ts_pkg;

   // Command codes of an input transaction
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_DRAIN = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   // Sample sources
   localparam logic [1:0] SRC_ADC  = 2'd0;
   localparam logic [1:0] SRC_SINE = 2'd1;
   localparam logic [1:0] SRC_TIME = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SOURCE_SELECT = 2'd0;
   localparam logic [1:0] CSR_TICK_DIVIDE   = 2'd1;
   localparam logic [1:0] CSR_PHASE_STEP    = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // Configuration reset values
   localparam logic [1:0]  SOURCE_RESET     = SRC_ADC;
   localparam logic [16:0] TICK_DIV_RESET   = 17'd1;
   localparam logic [23:0] PHASE_STEP_RESET = 24'd16777;

   // Sine output: 512 +/- amplitude, spans 0..1024
   localparam int SINE_BITS = 11;
   localparam int AMP_BITS  = 10;
   localparam logic [SINE_BITS-1:0] SINE_MID = 11'd512;

   // Q30 fixed point constants for the table builder
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [1:0]  command;
      logic [9:0]  adc_sample;
      logic [31:0] time_us;
      logic        run_continuous;
      logic [15:0] run_length;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] stamp_us;
      logic [31:0] reading;
      logic        missed;
      logic        run_done;
   } rsp_payload_type;

   // Control from the sampler core to the sine source
   typedef struct packed {
      logic clear;
      logic advance;
   } sine_ctl_type;

   // round(512 * sin(pi/2 * j / 2^qlog2)) by a Q30 Taylor series to the x^17 term
   function automatic logic [AMP_BITS-1:0] sine_amp(input int unsigned j,
                                                    input int unsigned qlog2);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] prod;
      logic [63:0] rounded;
      x = (HALF_PI_Q30 * 64'(j)) >> qlog2;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 8; n++) begin
         prod = (term * x2) >> 30;
         case (n)
            1:       term = prod / 64'd6;
            2:       term = prod / 64'd20;
            3:       term = prod / 64'd42;
            4:       term = prod / 64'd72;
            5:       term = prod / 64'd110;
            6:       term = prod / 64'd156;
            7:       term = prod / 64'd210;
            default: term = prod / 64'd272;
         endcase
         if ((n % 2) == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      rounded = (sum + (64'd1 << 20)) >> 21;
      return rounded[AMP_BITS-1:0];
   endfunction

endpackage

// File: rtl/ts_stream_if.sv
// Interface: valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface ts_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/ts_sine_source.sv
// Sine test source: phase accumulator and quarter-wave sine lookup.
`timescale 1ns / 1ps

module ts_sine_source
   import ts_pkg::*;
#(
   parameter int PHASE_BITS = 24,
   parameter int TABLE_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sine_ctl_type         ctl,
   input  logic [23:0]          phase_step,
   output logic [SINE_BITS-1:0] value_next
);

   localparam int QBITS   = TABLE_BITS - 2;
   localparam int QUARTER = 1 << QBITS;
   localparam logic [AMP_BITS-1:0] AMP_FULL = sine_amp(QUARTER, QBITS);

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_sum;
   logic [TABLE_BITS-1:0] index;
   logic [1:0]            quad;
   logic [QBITS-1:0]      j;
   logic [QBITS-1:0]      rom_addr;
   logic [AMP_BITS-1:0]   amp;
   logic [AMP_BITS-1:0]   amp_rom [QUARTER];

   // Build the quarter-wave amplitude table at elaboration
   for (genvar k = 0; k < QUARTER; k++) begin : g_rom
      localparam logic [AMP_BITS-1:0] AMP_K = sine_amp(k, QBITS);
      assign amp_rom[k] = AMP_K;
   end

   // Advance the phase first, then look up the new phase
   assign phase_sum = phase_ff + PHASE_BITS'(phase_step);
   assign index     = phase_sum[PHASE_BITS-1 -: TABLE_BITS];
   assign quad      = index[TABLE_BITS-1 -: 2];
   assign j         = index[QBITS-1:0];
   assign rom_addr  = quad[0] ? QBITS'(~j + 1'b1) : j;

   // Mirror odd quadrants; the peak sits just past the end of the table
   always_comb begin
      if (quad[0] && (j == '0)) begin
         amp = AMP_FULL;
      end else begin
         amp = amp_rom[rom_addr];
      end
      if (quad[1]) begin
         value_next = SINE_MID - SINE_BITS'(amp);
      end else begin
         value_next = SINE_MID + SINE_BITS'(amp);
      end
   end

   // Clear on a step write, advance on a sine sample
   always_comb begin
      phase_in = phase_ff;
      if (ctl.clear) begin
         phase_in = '0;
      end else if (ctl.advance) begin
         phase_in = phase_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// File: rtl/ts_sampler_core.sv
// Sampler core: prescaler, run control, held sample and configuration registers.
`timescale 1ns / 1ps

module ts_sampler_core
   import ts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  req_payload_type           item,
   input  logic                      fire,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic [SINE_BITS-1:0]      sine_value,
   output logic                      emit,
   output rsp_payload_type           result,
   output sine_ctl_type              sine_ctl,
   output logic [23:0]               phase_step
);

   logic [1:0]  source_ff,   source_in;
   logic [16:0] tick_div_ff, tick_div_in;
   logic [23:0] step_ff,     step_in;
   logic [16:0] tick_count_ff, tick_count_in;
   logic        pending_ff,    pending_in;
   logic        missed_ff,     missed_in;
   logic        continuous_ff, continuous_in;
   logic [15:0] remaining_ff,  remaining_in;
   logic [31:0] held_time_ff,  held_time_in;
   logic [31:0] held_value_ff, held_value_in;

   logic [16:0] div;
   logic [16:0] count_inc;
   logic        tick_due;
   logic        run_active;
   logic        take;

   // Prescaler compare; a zero divider acts as one
   assign div        = (tick_div_ff == '0) ? 17'd1 : tick_div_ff;
   assign count_inc  = tick_count_ff + 17'd1;
   assign tick_due   = count_inc >= div;
   assign run_active = continuous_ff || (remaining_ff != '0);
   assign take       = (item.command == CMD_TICK) && tick_due && run_active;

   // Result for a drain of a pending sample
   assign emit = item_valid && (item.command == CMD_DRAIN) && pending_ff;
   assign result.stamp_us = held_time_ff;
   assign result.reading  = held_value_ff;
   assign result.missed   = missed_ff;
   assign result.run_done = !continuous_ff && (remaining_ff == 16'd1);

   assign sine_ctl.clear   = csr_write_enable && (csr_index == CSR_PHASE_STEP);
   assign sine_ctl.advance = fire && take && (source_ff == SRC_SINE);
   assign phase_step       = step_ff;

   // Configuration writes
   always_comb begin
      source_in   = source_ff;
      tick_div_in = tick_div_ff;
      step_in     = step_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_SELECT: source_in   = csr_write_data[1:0];
            CSR_TICK_DIVIDE:   tick_div_in = csr_write_data[16:0];
            CSR_PHASE_STEP:    step_in     = csr_write_data;
            default:           ;
         endcase
      end
   end

   // Execute one transaction
   always_comb begin
      tick_count_in = tick_count_ff;
      pending_in    = pending_ff;
      missed_in     = missed_ff;
      continuous_in = continuous_ff;
      remaining_in  = remaining_ff;
      held_time_in  = held_time_ff;
      held_value_in = held_value_ff;
      if (fire) begin
         case (item.command)
            CMD_TICK: begin
               tick_count_in = tick_due ? count_inc - div : count_inc;
               if (take) begin
                  if (pending_ff) begin
                     missed_in = 1'b1;
                  end
                  pending_in   = 1'b1;
                  held_time_in = item.time_us;
                  case (source_ff)
                     SRC_ADC:  held_value_in = 32'(item.adc_sample);
                     SRC_SINE: held_value_in = 32'(sine_value);
                     SRC_TIME: held_value_in = item.time_us;
                     default:  ;
                  endcase
               end
            end
            CMD_DRAIN: begin
               if (pending_ff) begin
                  if (!continuous_ff && (remaining_ff != '0)) begin
                     remaining_in = remaining_ff - 16'd1;
                  end
                  pending_in = 1'b0;
                  missed_in  = 1'b0;
               end
            end
            CMD_START: begin
               continuous_in = item.run_continuous;
               remaining_in  = item.run_length;
               pending_in    = 1'b0;
               missed_in     = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff     <= SOURCE_RESET;
         tick_div_ff   <= TICK_DIV_RESET;
         step_ff       <= PHASE_STEP_RESET;
         tick_count_ff <= '0;
         pending_ff    <= 1'b0;
         missed_ff     <= 1'b0;
         continuous_ff <= 1'b0;
         remaining_ff  <= '0;
         held_time_ff  <= '0;
         held_value_ff <= '0;
      end else begin
         source_ff     <= source_in;
         tick_div_ff   <= tick_div_in;
         step_ff       <= step_in;
         tick_count_ff <= tick_count_in;
         pending_ff    <= pending_in;
         missed_ff     <= missed_in;
         continuous_ff <= continuous_in;
         remaining_ff  <= remaining_in;
         held_time_ff  <= held_time_in;
         held_value_ff <= held_value_in;
      end
   end

endmodule

// File: rtl/timed_sampler_with_sine_test_source.sv
// A drain's result is registered in the input register, then in the result register;
// a full result register can hold the drain in the input register between the two.
// Throughput: one transaction per cycle, as the core state is updated when each one
// advances; a full result register stalls only drains that carry a result.
// Synchronous active-high reset clears all but payload registers; restores defaults.
`timescale 1ns / 1ps

module timed_sampler_with_sine_test_source
   import ts_pkg::*;
#(
   parameter int PHASE_BITS = 24,
   parameter int TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   ts_stream_if.sink                 req_chan,
   ts_stream_if.source               rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff,  in_item_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_item_ff,  rsp_item_in;

   logic             emit;
   logic             fire;
   logic             out_free;
   rsp_payload_type  result;
   sine_ctl_type     sine_ctl;
   logic [23:0]      phase_step;
   logic [SINE_BITS-1:0] sine_value;

   // Advance the held transaction unless its result has nowhere to go
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && (!emit || out_free);
   assign req_chan.ready = !in_valid_ff || fire;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   ts_sampler_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (in_valid_ff),
      .item             (in_item_ff),
      .fire             (fire),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sine_value       (sine_value),
      .emit             (emit),
      .result           (result),
      .sine_ctl         (sine_ctl),
      .phase_step       (phase_step)
   );

   ts_sine_source #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (TABLE_BITS)
   ) u_sine (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sine_ctl),
      .phase_step (phase_step),
      .value_next (sine_value)
   );

   // Input register: load a new transaction, drop the one that advanced
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_chan.payload;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// File: tb/timed_sampler_with_sine_test_source_test.sv
// Self-checking testbench for the timed sampler with its sine test source.
`timescale 1ns / 1ps

module timed_sampler_with_sine_test_source_test;
   import ts_pkg::*;

   localparam int PHASE_W  = 24;
   localparam int LUT_BITS = 10;
   localparam int LUT_SIZE = 1 << LUT_BITS;
   localparam int QUIET_CYCLES = 6;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 165;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] SRC_UNUSED = 2'd3;
   localparam logic [63:0] HALF_PI_FX = 64'd1686629713;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   ts_stream_if #(.payload_type(req_payload_type)) req_if ();
   ts_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   timed_sampler_with_sine_test_source #(
      .PHASE_BITS(PHASE_W),
      .TABLE_BITS(LUT_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the sampler state and its registers
   logic [1:0]  m_source;
   logic [16:0] m_divide;
   logic [23:0] m_step;
   logic [16:0] m_count;
   logic [23:0] m_phase;
   logic        m_pending;
   logic        m_missed;
   logic        m_continuous;
   logic [15:0] m_remaining;
   logic [31:0] m_time;
   logic [31:0] m_value;
   logic [31:0] sine_lut [LUT_SIZE];

   req_payload_type pending_cmds[$];
   rsp_payload_type expected_samples[$];
   int unsigned queued_total = 0;
   int unsigned accepted_total = 0;
   int unsigned result_count = 0;
   int unsigned missed_count = 0;
   int unsigned done_count = 0;
   int unsigned error_count = 0;
   logic [31:0] now_us;

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;

   // round(512 * sin(pi/2 * j / quarter)) by a fixed point Taylor series
   function automatic logic [63:0] quarter_sine(logic [63:0] j, logic [63:0] quarter);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] divisor;
      x = (HALF_PI_FX * j) / quarter;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 8; n++) begin
         divisor = 64'((2 * n) * (2 * n + 1));
         term = ((term * x2) >> 30) / divisor;
         if ((n % 2) == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      return (acc + (64'd1 << 20)) >> 21;
   endfunction

   function automatic logic [31:0] sine_entry(int unsigned k);
      logic [63:0] quarter;
      logic [63:0] j;
      quarter = 64'd1 << (LUT_BITS - 2);
      j = 64'(k) & (quarter - 64'd1);
      case ((k >> (LUT_BITS - 2)) & 3)
         0: return 32'(64'd512 + quarter_sine(j, quarter));
         1: return 32'(64'd512 + quarter_sine(quarter - j, quarter));
         2: return 32'(64'd512 - quarter_sine(j, quarter));
         default: return 32'(64'd512 - quarter_sine(quarter - j, quarter));
      endcase
   endfunction

   function automatic void apply_config(logic [1:0] idx, logic [23:0] val);
      case (idx)
         CSR_SOURCE_SELECT: m_source = val[1:0];
         CSR_TICK_DIVIDE:   m_divide = val[16:0];
         CSR_PHASE_STEP: begin
            m_step = val;
            m_phase = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic void capture_sample(logic [9:0] adc, logic [31:0] stamp);
      if (!m_continuous && m_remaining == 16'd0) return;
      if (m_pending) m_missed = 1'b1;
      m_time = stamp;
      case (m_source)
         SRC_ADC:  m_value = {22'd0, adc};
         SRC_SINE: begin
            m_phase = m_phase + m_step;
            m_value = sine_lut[m_phase[PHASE_W-1 -: LUT_BITS]];
         end
         SRC_TIME: m_value = stamp;
         default:  ;
      endcase
      m_pending = 1'b1;
   endfunction

   // Advance the mirror by one accepted transaction and queue any drained sample
   function automatic void sampler_step(req_payload_type tr);
      logic [16:0] div_eff;
      rsp_payload_type out;
      case (tr.command)
         CMD_TICK: begin
            div_eff = (m_divide == 17'd0) ? 17'd1 : m_divide;
            m_count = m_count + 17'd1;
            if (m_count >= div_eff) begin
               m_count = m_count - div_eff;
               capture_sample(tr.adc_sample, tr.time_us);
            end
         end
         CMD_DRAIN: begin
            if (m_pending) begin
               out.run_done = 1'b0;
               if (!m_continuous && m_remaining != 16'd0) begin
                  m_remaining = m_remaining - 16'd1;
                  out.run_done = (m_remaining == 16'd0);
               end
               out.stamp_us = m_time;
               out.reading = m_value;
               out.missed = m_missed;
               expected_samples.push_back(out);
               m_pending = 1'b0;
               m_missed = 1'b0;
            end
         end
         CMD_START: begin
            m_continuous = tr.run_continuous;
            m_remaining = tr.run_length;
            m_missed = 1'b0;
            m_pending = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic int draw_wait(bit enabled);
      if (!enabled || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic req_payload_type make_item(logic [1:0] cmd);
      req_payload_type p;
      p.command = cmd;
      p.adc_sample = 10'($urandom);
      p.time_us = $urandom;
      p.run_continuous = 1'($urandom);
      p.run_length = 16'($urandom);
      return p;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Monitor: predict accepted requests, check accepted results
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            accepted_total++;
            sampler_step(req_if.payload);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken = 1'b1;
            if (expected_samples.size() == 0) begin
               error_count++;
               $display("%0t: unexpected sample: expected none, actual %h", $time,
                        rsp_if.payload);
            end else begin
               want = expected_samples.pop_front();
               result_count++;
               if (want.missed) missed_count++;
               if (want.run_done) done_count++;
               check_field("stamp_us", want.stamp_us, rsp_if.payload.stamp_us);
               check_field("reading", want.reading, rsp_if.payload.reading);
               check_field("missed", 32'(want.missed), 32'(rsp_if.payload.missed));
               check_field("run_done", 32'(want.run_done), 32'(rsp_if.payload.run_done));
            end
         end
      end
   end

   // Driver: present queued requests with random gaps between transactions
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else if (!req_if.valid || req_taken) begin
         if (req_taken) req_gap = draw_wait(req_idle_on);
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
         end else if (pending_cmds.size() != 0) begin
            req_if.payload <= pending_cmds.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side: stall each result for a random number of cycles
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_taken) rsp_stall = draw_wait(rsp_idle_on);
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            if (rsp_if.valid) rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic push_item(req_payload_type p);
      pending_cmds.push_back(p);
      queued_total++;
   endtask

   task automatic send_tick(logic [9:0] adc, logic [31:0] stamp);
      req_payload_type p;
      p = make_item(CMD_TICK);
      p.adc_sample = adc;
      p.time_us = stamp;
      push_item(p);
   endtask

   task automatic send_start(logic continuous, logic [15:0] length);
      req_payload_type p;
      p = make_item(CMD_START);
      p.run_continuous = continuous;
      p.run_length = length;
      push_item(p);
   endtask

   // Hold until every transaction is in and every sample is out
   task automatic wait_quiet();
      while (pending_cmds.size() != 0 || accepted_total != queued_total ||
             expected_samples.size() != 0)
         @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_index = idx;
      csr_write_data = val;
      csr_write_enable = 1'b1;
      apply_config(idx, val);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 15))
         0:       return 16'd0;
         1, 2:    return 16'($urandom);
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   // Mostly well-formed runs (start, ticks, drains), with some arbitrary noise
   task automatic queue_random(int unsigned count);
      int unsigned made;
      int unsigned ticks;
      int unsigned div_eff;
      req_payload_type p;
      made = 0;
      div_eff = (m_divide == 17'd0) ? 1 : int'(m_divide);
      while (made < count) begin
         if ($urandom_range(0, 9) < 8) begin
            send_start($urandom_range(0, 3) == 0, pick_length());
            made++;
            repeat ($urandom_range(1, 10)) begin
               ticks = $urandom_range(1, 2 * div_eff);
               repeat (ticks) begin
                  now_us = now_us + 32'($urandom_range(1, 3000));
                  if ($urandom_range(0, 7) == 0) now_us = $urandom;
                  send_tick(10'($urandom), now_us);
               end
               made += ticks;
               if ($urandom_range(0, 4) != 0) begin
                  push_item(make_item(CMD_DRAIN));
                  made++;
               end
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               p = make_item(2'($urandom));
               push_item(p);
               if (p.command != CMD_UNUSED) made++;
            end
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("timed_sampler_with_sine_test_source test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      m_source = SOURCE_RESET;
      m_divide = TICK_DIV_RESET;
      m_step = PHASE_STEP_RESET;
      m_count = '0;
      m_phase = '0;
      m_pending = 1'b0;
      m_missed = 1'b0;
      m_continuous = 1'b0;
      m_remaining = '0;
      m_time = '0;
      m_value = '0;
      now_us = $urandom;
      for (int k = 0; k < LUT_SIZE; k++) sine_lut[k] = sine_entry(k);
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Default registers: empty drain, ignored command, counted run with overwrite
      push_item(make_item(CMD_DRAIN));
      push_item(make_item(CMD_UNUSED));
      send_start(1'b0, 16'd2);
      send_tick(10'd0, 32'd0);
      push_item(make_item(CMD_DRAIN));
      send_tick(10'h3FF, 32'hFFFF_FFFF);
      send_tick(10'd512, 32'd7);
      push_item(make_item(CMD_DRAIN));
      send_tick(10'h155, 32'd9);
      push_item(make_item(CMD_DRAIN));
      send_start(1'b1, 16'hFFFF);
      send_tick(10'h2AA, 32'h8000_0000);
      push_item(make_item(CMD_DRAIN));
      wait_quiet();

      // Sine source, divider zero, largest phase step
      write_reg(CSR_SOURCE_SELECT, 24'(SRC_SINE));
      write_reg(CSR_TICK_DIVIDE, 24'd0);
      write_reg(CSR_PHASE_STEP, 24'hFF_FFFF);
      send_tick(10'd1, 32'd100);
      send_tick(10'd2, 32'd200);
      push_item(make_item(CMD_DRAIN));
      wait_quiet();

      // A large divider, then lower it below the count
      write_reg(CSR_SOURCE_SELECT, 24'(SRC_TIME));
      write_reg(CSR_TICK_DIVIDE, 24'd65536);
      repeat (3) send_tick(10'($urandom), $urandom);
      wait_quiet();
      write_reg(CSR_TICK_DIVIDE, 24'd2);
      send_tick(10'd3, 32'h1234_5678);
      push_item(make_item(CMD_DRAIN));
      wait_quiet();

      // Unused source keeps the previous value
      write_reg(CSR_SOURCE_SELECT, 24'(SRC_UNUSED));
      send_tick(10'd4, 32'h0BAD_F00D);
      push_item(make_item(CMD_DRAIN));
      send_start(1'b0, 16'd0);
      send_tick(10'd5, 32'd55);
      wait_quiet();

      // Random phases over sources, dividers and phase steps
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0:       write_reg(CSR_SOURCE_SELECT, 24'(SRC_ADC));
            1:       write_reg(CSR_SOURCE_SELECT, 24'(SRC_SINE));
            2:       write_reg(CSR_SOURCE_SELECT, 24'(SRC_TIME));
            default: write_reg(CSR_SOURCE_SELECT, 24'(SRC_UNUSED));
         endcase
         case (ph)
            3:       write_reg(CSR_TICK_DIVIDE, 24'd0);
            4:       write_reg(CSR_TICK_DIVIDE, 24'd1);
            default: write_reg(CSR_TICK_DIVIDE, 24'($urandom_range(1, 6)));
         endcase
         case (ph)
            1:       write_reg(CSR_PHASE_STEP, 24'd0);
            5:       write_reg(CSR_PHASE_STEP, 24'hFF_FFFF);
            default: write_reg(CSR_PHASE_STEP, 24'($urandom));
         endcase
         req_idle_on = (ph % 3) != 0;
         rsp_idle_on = $urandom_range(0, 2) != 0;
         queue_random(PHASE_ITEMS);
         wait_quiet();
      end

      $display("Covered %0d request transactions over all sources and dividers;",
               accepted_total);
      $display("checked %0d drained samples, %0d with missed set, %0d ending a run.",
               result_count, missed_count, done_count);
      if (error_count == 0) begin
         $display("timed_sampler_with_sine_test_source test passed");
      end else begin
         $display("timed_sampler_with_sine_test_source test failed");
      end
      $finish;
   end

endmodule
